/* design/chalmt_pkg.sv */
// Shared types and constants for the channel allocator with member table.
// Used by chalmt_ctrl, chalmt_dp and channel_allocator_member_table; no dependencies.
package chalmt_pkg;

  localparam logic [31:0] NO_MEMBER = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    MODE_CREATE  = 3'd0,
    MODE_DESTROY = 3'd1,
    MODE_ADD     = 3'd2,
    MODE_DELETE  = 3'd3,
    MODE_QUERY   = 3'd4,
    MODE_READ    = 3'd5
  } mode_t;

  // controller -> datapath, at most one high per cycle
  typedef struct packed {
    logic clr;     // clear one channel entry after reset
    logic accept;  // take the request
    logic scan;    // test one channel for create
    logic info;    // act on the channel entry
    logic srch;    // compare one member slot
    logic shift;   // move one member slot down
    logic rdata;   // take the member read
    logic load;    // move the result to the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic in_create;
    logic in_ch_ok;
    logic scan_hit;
    logic scan_last;
    logic need_srch;
    logic need_read;
    logic match;
    logic at_last;
    logic is_delete;
    logic out_free;
  } sts_t;

endpackage

/* design/chalmt_ctrl.sv */
// Sequencer for the channel allocator: one request at a time through its phases.
// Depends on chalmt_pkg (cmd_t, sts_t).
module chalmt_ctrl import chalmt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_SCAN  = 8'b0000_0100,
    ST_INFO  = 8'b0000_1000,
    ST_SRCH  = 8'b0001_0000,
    ST_SHIFT = 8'b0010_0000,
    ST_RDATA = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_create) state_nxt = ST_SCAN;
          else if (!sts.in_ch_ok) state_nxt = ST_DONE;
          else state_nxt = ST_INFO;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit || sts.scan_last) state_nxt = ST_DONE;
      end
      ST_INFO: begin
        cmd.info = 1'b1;
        if (sts.need_srch) state_nxt = ST_SRCH;
        else if (sts.need_read) state_nxt = ST_RDATA;
        else state_nxt = ST_DONE;
      end
      ST_SRCH: begin
        cmd.srch = 1'b1;
        if (sts.match) begin
          state_nxt = (sts.is_delete && !sts.at_last) ? ST_SHIFT : ST_DONE;
        end else if (sts.at_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.at_last) state_nxt = ST_DONE;
      end
      ST_RDATA: begin
        cmd.rdata = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/chalmt_dp.sv */
// Datapath of the channel allocator: channel table, member memory, pointers, result regs.
// Depends on chalmt_pkg (mode_t, cmd_t, sts_t, NO_MEMBER).
module chalmt_dp import chalmt_pkg::*; #(
  parameter int CHANNELS = 64,
  parameter int MEMBERS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  in_mode,
  input  logic [5:0]  in_channel,
  input  logic [31:0] in_member_id,
  input  logic [3:0]  in_member_index,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [5:0]  out_channel_id,
  output logic [31:0] out_member_value,
  output logic [4:0]  out_member_count,
  output logic [6:0]  out_channel_count
);

  localparam int CH_W   = $clog2(CHANNELS);
  localparam int CNT_W  = $clog2(MEMBERS + 1);
  localparam int DEPTH  = CHANNELS * MEMBERS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int UC_W   = $clog2(CHANNELS + 1);
  localparam int INFO_W = 1 + 2 * CNT_W;

  localparam logic [CH_W-1:0]   CH_LAST   = CH_W'(CHANNELS - 1);
  localparam logic [CNT_W-1:0]  MEM_FULL  = CNT_W'(MEMBERS);
  localparam logic [ADDR_W-1:0] MEMBERS_A = ADDR_W'(MEMBERS);

  // channel entry: {in use, member count, high-water mark}
  // slots at or above the high-water mark were not written since the last clear or destroy
  logic [INFO_W-1:0] info_mem [CHANNELS];
  logic [INFO_W-1:0] info_rd_r;
  logic [31:0]       mem [DEPTH];
  logic [31:0]       mem_rd_r;

  mode_t             mode_r, mode_nxt;
  logic [31:0]       id_r, id_nxt;
  logic [3:0]        midx_r, midx_nxt;
  logic [CH_W-1:0]   chaddr_r, chaddr_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [CH_W-1:0]   ptr_r, ptr_nxt;
  logic [UC_W-1:0]   used_r, used_nxt;
  logic [CH_W-1:0]   probe_r, probe_nxt;
  logic [CH_W-1:0]   tries_r, tries_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CH_W-1:0]   clr_r, clr_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic [5:0]        res_ch_r, res_ch_nxt;
  logic [31:0]       res_val_r, res_val_nxt;
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r;
  logic [5:0]        out_ch_r;
  logic [31:0]       out_val_r;
  logic [4:0]        out_cnt_r;
  logic [6:0]        out_used_r;

  logic              info_we, info_re;
  logic [CH_W-1:0]   info_wa, info_ra;
  logic [INFO_W-1:0] info_wd;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [31:0]       mem_wd;

  logic              info_use;
  logic [CNT_W-1:0]  info_cnt, info_hw, idx_inc;
  logic [CH_W-1:0]   in_chaddr, probe_wrap;
  logic              id_ok, full, rd_idx_ok, rd_hw_ok, is_search;

  assign info_use   = info_rd_r[INFO_W-1];
  assign info_cnt   = info_rd_r[2*CNT_W-1:CNT_W];
  assign info_hw    = info_rd_r[CNT_W-1:0];
  assign idx_inc    = idx_r + CNT_W'(1);
  assign in_chaddr  = CH_W'(in_channel);
  assign probe_wrap = (probe_r == CH_LAST) ? '0 : probe_r + CH_W'(1);
  assign id_ok      = id_r != NO_MEMBER;
  assign full       = info_cnt == MEM_FULL;
  assign rd_idx_ok  = 9'(midx_r) < 9'(MEMBERS);
  assign rd_hw_ok   = 9'(midx_r) < 9'(info_hw);
  assign is_search  = mode_r == MODE_DELETE || mode_r == MODE_QUERY;

  always_comb begin
    sts           = '0;
    sts.clr_last  = clr_r == CH_LAST;
    sts.in_create = in_mode == MODE_CREATE;
    sts.in_ch_ok  = 11'(in_channel) < 11'(CHANNELS);
    sts.scan_hit  = !info_use;
    sts.scan_last = tries_r == CH_LAST;
    sts.need_srch = is_search && id_ok && info_cnt != '0;
    sts.need_read = mode_r == MODE_READ && info_use && info_cnt != '0 && rd_idx_ok;
    sts.match     = mem_rd_r == id_r;
    sts.at_last   = idx_inc == info_cnt;
    sts.is_delete = mode_r == MODE_DELETE;
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    mode_nxt    = mode_r;
    id_nxt      = id_r;
    midx_nxt    = midx_r;
    chaddr_nxt  = chaddr_r;
    base_nxt    = base_r;
    ptr_nxt     = ptr_r;
    used_nxt    = used_r;
    probe_nxt   = probe_r;
    tries_nxt   = tries_r;
    idx_nxt     = idx_r;
    clr_nxt     = clr_r;
    res_ok_nxt  = res_ok_r;
    res_ch_nxt  = res_ch_r;
    res_val_nxt = res_val_r;
    res_cnt_nxt = res_cnt_r;
    info_we     = 1'b0;
    info_wa     = chaddr_r;
    info_wd     = '0;
    info_re     = 1'b0;
    info_ra     = chaddr_r;
    mem_we      = 1'b0;
    mem_wa      = base_r;
    mem_wd      = id_r;
    mem_re      = 1'b0;
    mem_ra      = base_r + ADDR_W'(idx_inc);

    if (cmd.clr) begin
      info_we = 1'b1;
      info_wa = clr_r;
      clr_nxt = sts.clr_last ? clr_r : clr_r + CH_W'(1);
    end

    if (cmd.accept) begin
      mode_nxt    = mode_t'(in_mode);
      id_nxt      = in_member_id;
      midx_nxt    = in_member_index;
      chaddr_nxt  = in_chaddr;
      base_nxt    = ADDR_W'(in_chaddr) * MEMBERS_A;
      probe_nxt   = ptr_r;
      tries_nxt   = '0;
      idx_nxt     = '0;
      info_re     = 1'b1;
      info_ra     = sts.in_create ? ptr_r : in_chaddr;
      res_ok_nxt  = 1'b0;
      res_ch_nxt  = in_channel;
      res_val_nxt = NO_MEMBER;
      res_cnt_nxt = '0;
    end

    if (cmd.scan) begin
      if (!info_use) begin
        info_we     = 1'b1;
        info_wa     = probe_r;
        info_wd     = {1'b1, info_cnt, info_hw};
        ptr_nxt     = probe_wrap;
        used_nxt    = used_r + UC_W'(1);
        res_ok_nxt  = 1'b1;
        res_ch_nxt  = 6'(probe_r);
        res_cnt_nxt = info_cnt;
      end else if (sts.scan_last) begin
        // table full: every channel was probed; the pointer is unchanged
        res_ch_nxt  = '0;
        res_cnt_nxt = '0;
      end else begin
        probe_nxt = probe_wrap;
        tries_nxt = tries_r + CH_W'(1);
        info_re   = 1'b1;
        info_ra   = probe_wrap;
      end
    end

    if (cmd.info) begin
      res_cnt_nxt = info_cnt;
      unique case (mode_r)
        MODE_DESTROY: begin
          info_we     = 1'b1;
          info_wd     = '0;
          res_ok_nxt  = 1'b1;
          res_cnt_nxt = '0;
          if (info_use && used_r != '0) used_nxt = used_r - UC_W'(1);
        end
        MODE_ADD: begin
          if (id_ok && !full) begin
            mem_we      = 1'b1;
            mem_wa      = base_r + ADDR_W'(info_cnt);
            info_we     = 1'b1;
            info_wd     = {info_use, info_cnt + CNT_W'(1),
                           (info_cnt == info_hw) ? info_cnt + CNT_W'(1) : info_hw};
            res_ok_nxt  = 1'b1;
            res_cnt_nxt = info_cnt + CNT_W'(1);
          end
        end
        MODE_DELETE, MODE_QUERY: begin
          mem_re = 1'b1;
          mem_ra = base_r;
        end
        MODE_READ: begin
          mem_re = 1'b1;
          mem_ra = rd_idx_ok ? base_r + ADDR_W'(midx_r) : base_r;
        end
        default: ;
      endcase
    end

    if (cmd.srch) begin
      if (sts.match) begin
        res_ok_nxt = 1'b1;
        if (sts.is_delete) begin
          if (sts.at_last) begin
            info_we     = 1'b1;
            info_wd     = {info_use, info_cnt - CNT_W'(1), info_hw};
            res_cnt_nxt = info_cnt - CNT_W'(1);
          end else begin
            idx_nxt = idx_inc;
            mem_re  = 1'b1;
          end
        end
      end else if (!sts.at_last) begin
        idx_nxt = idx_inc;
        mem_re  = 1'b1;
      end
    end

    if (cmd.shift) begin
      // move the slot just read one place down; the vacated last slot keeps its value
      mem_we = 1'b1;
      mem_wa = base_r + ADDR_W'(idx_r - CNT_W'(1));
      mem_wd = mem_rd_r;
      if (sts.at_last) begin
        info_we     = 1'b1;
        info_wd     = {info_use, info_cnt - CNT_W'(1), info_hw};
        res_cnt_nxt = info_cnt - CNT_W'(1);
      end else begin
        idx_nxt = idx_inc;
        mem_re  = 1'b1;
      end
    end

    if (cmd.rdata) begin
      res_ok_nxt  = 1'b1;
      res_val_nxt = rd_hw_ok ? mem_rd_r : NO_MEMBER;
    end

    if (cmd.load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    if (info_re) info_rd_r <= info_mem[info_ra];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_rd_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      used_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r       <= ptr_nxt;
      used_r      <= used_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    id_r      <= id_nxt;
    midx_r    <= midx_nxt;
    chaddr_r  <= chaddr_nxt;
    base_r    <= base_nxt;
    probe_r   <= probe_nxt;
    tries_r   <= tries_nxt;
    idx_r     <= idx_nxt;
    res_ok_r  <= res_ok_nxt;
    res_ch_r  <= res_ch_nxt;
    res_val_r <= res_val_nxt;
    res_cnt_r <= res_cnt_nxt;
    if (cmd.load) begin
      out_ok_r   <= res_ok_r;
      out_ch_r   <= res_ch_r;
      out_val_r  <= res_val_r;
      out_cnt_r  <= 5'(res_cnt_r);
      out_used_r <= 7'(used_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_channel_id    = out_ch_r;
  assign out_member_value  = out_val_r;
  assign out_member_count  = out_cnt_r;
  assign out_channel_count = out_used_r;

endmodule

/* design/channel_allocator_member_table.sv */
// Top level of the channel allocator with per-channel member lists.
// Depends on chalmt_pkg, chalmt_ctrl and chalmt_dp.
//
//   channel  direction  handshake             payload
//   in_      in         in_valid/in_ready     mode, channel, member_id, member_index
//   out_     out        out_valid/out_ready   ok, channel_id, member_value,
//                                             member_count, channel_count
//
// One request at a time. After accept, destroy, add and unused modes pass the info and
// done states, an out-of-range channel goes straight to done, a read of an active
// channel adds a read-data state, delete and query add at most member count slot steps
// (one slot compare or shift per cycle), create scans up to CHANNELS channels (one
// channel table read per cycle). After reset the table is cleared one entry a cycle;
// in_ready stays low until the clear is done. A result waiting in the output register
// is held while the next request is taken; the block stalls only when a second result is ready.
module channel_allocator_member_table import chalmt_pkg::*; #(
  parameter int CHANNELS = 64,
  parameter int MEMBERS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [5:0]  in_channel,
  input  logic [31:0] in_member_id,
  input  logic [3:0]  in_member_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [5:0]  out_channel_id,
  output logic [31:0] out_member_value,
  output logic [4:0]  out_member_count,
  output logic [6:0]  out_channel_count
);

  cmd_t cmd;
  sts_t sts;

  chalmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  chalmt_dp #(
    .CHANNELS (CHANNELS),
    .MEMBERS  (MEMBERS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mode           (in_mode),
    .in_channel        (in_channel),
    .in_member_id      (in_member_id),
    .in_member_index   (in_member_index),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ok            (out_ok),
    .out_channel_id    (out_channel_id),
    .out_member_value  (out_member_value),
    .out_member_count  (out_member_count),
    .out_channel_count (out_channel_count)
  );

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> sts.out_free)
    else $error("result loaded over an unread result");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in progress");

  a_fail_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> out_member_value == NO_MEMBER)
    else $error("failed request returned a member value");

endmodule
